@@ src/csq_pkg.sv @@
// ----------------------------------------------------------------------------
// csq_pkg: shared types and constants
// widths, command and status codes, queue request and response structs
// ----------------------------------------------------------------------------
package csq_pkg;

    localparam int MAX_WAITERS = 16;
    localparam int QW          = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int LW          = $clog2(MAX_WAITERS + 1);
    localparam int CNT_W       = 16;
    localparam int ID_W        = 8;
    localparam int VALUE_W     = 17;

    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
    localparam logic [VALUE_W-1:0] VALUE_NEG = '1;

    typedef enum logic [2:0] {
        CMD_WAIT    = 3'd0,
        CMD_TEST    = 3'd1,
        CMD_SIGNAL  = 3'd2,
        CMD_READ    = 3'd3,
        CMD_TIMEOUT = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        ST_GRANTED  = 4'd0,
        ST_QUEUED   = 4'd1,
        ST_BLOCK    = 4'd2,
        ST_WOKE     = 4'd3,
        ST_INCR     = 4'd4,
        ST_VALUE    = 4'd5,
        ST_REMOVED  = 4'd6,
        ST_NOTFOUND = 4'd7,
        ST_FULL     = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        Q_NONE,
        Q_PUSH,
        Q_POP,
        Q_REMOVE
    } q_op_t;

    typedef struct packed {
        q_op_t            op;
        logic [ID_W-1:0]  id;
    } q_req_t;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [ID_W-1:0]  id;
    } q_rsp_t;

    typedef enum logic [2:0] {
        QS_IDLE,
        QS_POP,
        QS_SCAN_RD,
        QS_SCAN_CMP,
        QS_SHIFT_RD,
        QS_SHIFT_WR,
        QS_DONE
    } q_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_QUEUE,
        T_OUT
    } top_state_t;

endpackage

@@ src/csq_queue.sv @@
// ----------------------------------------------------------------------------
// csq_queue: waiter queue engine
// circular buffer in a one-port memory with a small sequencer that pushes,
// pops, and scans and compacts the queue to remove a named waiter
// ----------------------------------------------------------------------------
module csq_queue
    import csq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         clear,
    input  q_req_t       req,
    output q_rsp_t       rsp,
    output logic [LW-1:0] len
);

    localparam int SW = LW + 1;

    logic [ID_W-1:0] mem [MAX_WAITERS];

    q_state_t        state_reg, state_next;
    logic [QW-1:0]   head_reg, head_next;
    logic [LW-1:0]   len_reg, len_next;
    logic [LW-1:0]   off_reg, off_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic            found_reg, found_next;
    logic [ID_W-1:0] out_id_reg, out_id_next;
    logic [ID_W-1:0] rd_data_reg;

    logic            mem_we;
    logic            mem_re;
    logic [ID_W-1:0] mem_wdata;
    logic [LW-1:0]   sel_off;
    logic [SW-1:0]   addr_sum;
    logic [SW-1:0]   addr_wrap;
    logic [QW-1:0]   addr;
    logic [QW-1:0]   head_inc;
    logic            more_scan;
    logic            more_shift;
    logic            match;

    // shared address unit: queue offset to physical slot
    always_comb
    begin
        addr_sum  = SW'(head_reg) + SW'(sel_off);
        addr_wrap = (addr_sum >= SW'(MAX_WAITERS)) ? addr_sum - SW'(MAX_WAITERS) : addr_sum;
        addr      = addr_wrap[QW-1:0];
    end

    assign head_inc   = (head_reg == QW'(MAX_WAITERS - 1)) ? '0 : head_reg + 1'b1;
    assign more_scan  = (off_reg + LW'(1)) < len_reg;
    assign more_shift = (off_reg + LW'(2)) < len_reg;
    assign match      = (rd_data_reg == id_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            QS_IDLE:
            begin
                case (req.op)
                    Q_PUSH:   state_next = QS_DONE;
                    Q_POP:    state_next = QS_POP;
                    Q_REMOVE: state_next = (len_reg == '0) ? QS_DONE : QS_SCAN_RD;
                    default:  state_next = QS_IDLE;
                endcase
            end
            QS_POP:      state_next = QS_DONE;
            QS_SCAN_RD:  state_next = QS_SCAN_CMP;
            QS_SCAN_CMP:
            begin
                if (match)
                    state_next = more_scan ? QS_SHIFT_RD : QS_DONE;
                else
                    state_next = more_scan ? QS_SCAN_RD : QS_DONE;
            end
            QS_SHIFT_RD: state_next = QS_SHIFT_WR;
            QS_SHIFT_WR: state_next = more_shift ? QS_SHIFT_RD : QS_DONE;
            QS_DONE:     state_next = QS_IDLE;
            default:     state_next = QS_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        head_next   = head_reg;
        len_next    = len_reg;
        off_next    = off_reg;
        id_next     = id_reg;
        found_next  = found_reg;
        out_id_next = out_id_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_wdata   = req.id;
        sel_off     = off_reg;
        case (state_reg)
            QS_IDLE:
            begin
                case (req.op)
                    Q_PUSH:
                    begin
                        sel_off  = len_reg;
                        mem_we   = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                    Q_POP:
                    begin
                        sel_off = '0;
                        mem_re  = 1'b1;
                    end
                    Q_REMOVE:
                    begin
                        id_next    = req.id;
                        off_next   = '0;
                        found_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            QS_POP:
            begin
                out_id_next = rd_data_reg;
                head_next   = head_inc;
                len_next    = len_reg - 1'b1;
            end
            QS_SCAN_RD:
            begin
                mem_re = 1'b1;
            end
            QS_SCAN_CMP:
            begin
                if (match)
                begin
                    found_next = 1'b1;
                    // match in the last slot: nothing to close up
                    if (!more_scan)
                        len_next = len_reg - 1'b1;
                end
                else if (more_scan)
                begin
                    off_next = off_reg + 1'b1;
                end
            end
            QS_SHIFT_RD:
            begin
                sel_off = off_reg + 1'b1;
                mem_re  = 1'b1;
            end
            QS_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg;
                if (more_shift)
                    off_next = off_reg + 1'b1;
                else
                    len_next = len_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= QS_IDLE;
            head_reg  <= '0;
            len_reg   <= '0;
        end
        else if (clear)
        begin
            state_reg <= QS_IDLE;
            head_reg  <= '0;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg    <= off_next;
        id_reg     <= id_next;
        found_reg  <= found_next;
        out_id_reg <= out_id_next;
    end

    // waiter id store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[addr];
    end

    assign rsp.done  = (state_reg == QS_DONE);
    assign rsp.found = found_reg;
    assign rsp.id    = out_id_reg;
    assign len       = len_reg;

endmodule

@@ src/counting_semaphore_wait_queue_unit.sv @@
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_unit: counting semaphore with fifo wait queue
// grant, block, increment, read and full go from accept to the output register;
//   a queued wait, a wake and a timeout first run the queue sequencer, a timeout
//   scanning entries and closing up the gap behind a match
// flow: one item at a time; the next command is taken once the last result is
//   loaded, and the single-port waiter memory and its scan sequencer hold it
// reset: count and queue empty, no result pending; the store needs no sweep
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_unit
    import csq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // initial count register, also empties the queue
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // command items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cmd[2:0], waiter[10:3], zero pad
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // status[3:0], woken[11:4], value[28:12], zero pad
);

    top_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    status_t          pend_status_reg, pend_status_next;
    logic [ID_W-1:0]  pend_woken_reg, pend_woken_next;
    logic             m_tvalid_reg, m_tvalid_next;
    status_t          out_status_reg, out_status_next;
    logic [ID_W-1:0]  out_woken_reg, out_woken_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;

    cmd_t             in_cmd;
    logic [ID_W-1:0]  in_waiter;
    logic             accept;
    logic             out_load;
    q_req_t           q_req;
    q_rsp_t           q_rsp;
    logic [LW-1:0]    q_len;

    // input unpacking
    assign in_cmd    = cmd_t'(s_tdata[2:0]);
    assign in_waiter = s_tdata[10:3];

    assign s_tready = (state_reg == T_IDLE);
    assign accept   = s_tvalid && s_tready;
    // output register frees when empty or being drained this cycle
    assign out_load = (state_reg == T_OUT) && (!m_tvalid_reg || m_tready);

    csq_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cfg_wr_en),
        .req   (q_req),
        .rsp   (q_rsp),
        .len   (q_len)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                    state_next = (q_req.op != Q_NONE) ? T_QUEUE : T_OUT;
            end
            T_QUEUE:
            begin
                if (q_rsp.done)
                    state_next = T_OUT;
            end
            T_OUT:
            begin
                if (out_load)
                    state_next = T_IDLE;
            end
            default: state_next = T_IDLE;
        endcase
    end

    // command decode, count update and result assembly
    always_comb
    begin
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        pend_woken_next  = pend_woken_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_woken_next   = out_woken_reg;
        out_value_next   = out_value_reg;
        q_req.op         = Q_NONE;
        q_req.id         = in_waiter;
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    pend_woken_next = '0;
                    case (in_cmd)
                        CMD_WAIT:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next       = count_reg - 1'b1;
                                pend_status_next = ST_GRANTED;
                            end
                            else if (q_len < LW'(MAX_WAITERS))
                            begin
                                q_req.op         = Q_PUSH;
                                pend_status_next = ST_QUEUED;
                            end
                            else
                            begin
                                pend_status_next = ST_FULL;
                            end
                        end
                        CMD_TEST:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next       = count_reg - 1'b1;
                                pend_status_next = ST_GRANTED;
                            end
                            else
                            begin
                                pend_status_next = ST_BLOCK;
                            end
                        end
                        CMD_SIGNAL:
                        begin
                            if (q_len != '0)
                            begin
                                q_req.op         = Q_POP;
                                pend_status_next = ST_WOKE;
                            end
                            else
                            begin
                                // saturates at the top of the range
                                if (count_reg != CNT_MAX)
                                    count_next = count_reg + 1'b1;
                                pend_status_next = ST_INCR;
                            end
                        end
                        CMD_TIMEOUT:
                        begin
                            q_req.op         = Q_REMOVE;
                            pend_status_next = ST_REMOVED;
                        end
                        default:
                        begin
                            // read and the unused codes
                            pend_status_next = ST_VALUE;
                        end
                    endcase
                end
            end
            T_QUEUE:
            begin
                if (q_rsp.done)
                begin
                    if (pend_status_reg == ST_REMOVED && !q_rsp.found)
                        pend_status_next = ST_NOTFOUND;
                    if (pend_status_reg == ST_WOKE)
                        pend_woken_next = q_rsp.id;
                end
            end
            T_OUT:
            begin
                if (out_load)
                begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = pend_status_reg;
                    out_woken_next  = pend_woken_reg;
                    // -1 while anyone is still queued
                    out_value_next  = (q_len != '0) ? VALUE_NEG : {1'b0, count_reg};
                end
            end
            default:
            begin
            end
        endcase
        if (cfg_wr_en)
            count_next = cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_woken_reg  <= pend_woken_next;
        out_status_reg  <= out_status_next;
        out_woken_reg   <= out_woken_next;
        out_value_reg   <= out_value_next;
    end

    // result packing
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_value_reg, out_woken_reg, out_status_reg};

endmodule

@@ tb/sv/counting_semaphore_wait_queue_unit_tb.sv @@
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_unit_tb: self-checking bench for the semaphore
// a directed table covers the corner cases (empty, full queue, duplicate ids,
// timeouts that miss or hit, saturation, spare command codes, reload while
// waiters are queued); seven random phases follow, each with an initial
// count and an idling pattern on both streams, and every result item is
// checked field by field against the table or a behavioural model of the semaphore
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_unit_tb;
    import csq_pkg::*;

    // spare command codes, decoded by the block as a plain read
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam int ITEMS_PER_PHASE = 145;
    localparam int NUM_PHASES      = 7;
    localparam int HOLD_CYCLES     = 300;      // long receiver hold-off
    localparam int TAIL_CYCLES     = 40;       // idle tail after the last result is back
    localparam int CYCLE_LIMIT     = 1000000;

    typedef struct packed {
        status_t              status;
        logic [ID_W-1:0]      woken;
        logic [VALUE_W-1:0]   value;
    } sem_result_t;

    // one row of the directed table: either a register write or a run of
    // commands; a run of several bumps the id by one per item
    typedef struct {
        logic                 is_cfg;
        logic [CNT_W-1:0]     cfg_val;
        logic [2:0]           op;
        logic [ID_W-1:0]      who;
        int                   reps;
        logic                 known;
        status_t              status;
        logic [ID_W-1:0]      woken;
        logic [VALUE_W-1:0]   value;
    } step_row_t;

    localparam int NUM_ROWS = 26;

    // dut ports, inputs at known values from time zero
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;   // cmd[2:0], waiter[10:3], zero pad
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;            // status[3:0], woken[11:4], value[28:12], zero pad

    // model state of the semaphore
    logic [CNT_W-1:0] sem_count = '0;
    logic [ID_W-1:0]  waiter_ids[$];

    // results still owed by the block, oldest first
    sem_result_t pending_results[$];

    int mismatches     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int count_settings = 0;
    int status_seen[9] = '{default: 0};
    int cycle_count    = 0;

    // pacing knobs, written by the stimulus process; holds_served by the receiver
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int holds_asked    = 0;
    int holds_served   = 0;

    step_row_t directed_steps[NUM_ROWS] = '{
        // fresh out of reset: count 0, nobody waiting
        '{1'b0, 16'h0000, CMD_READ,     8'h00, 1,  1'b1, ST_VALUE,    8'h00, 17'd0},
        '{1'b0, 16'h0000, CMD_TEST,     8'h5A, 1,  1'b1, ST_BLOCK,    8'h00, 17'd0},
        '{1'b0, 16'h0000, CMD_SPARE_HI, 8'hFF, 1,  1'b1, ST_VALUE,    8'h00, 17'd0},
        '{1'b0, 16'h0000, CMD_SIGNAL,   8'h00, 1,  1'b1, ST_INCR,     8'h00, 17'd1},
        '{1'b0, 16'h0000, CMD_TEST,     8'h00, 1,  1'b1, ST_GRANTED,  8'h00, 17'd0},
        '{1'b0, 16'h0000, CMD_TIMEOUT,  8'h33, 1,  1'b1, ST_NOTFOUND, 8'h00, 17'd0},
        // same id queued twice, then fill the queue up to its depth
        '{1'b0, 16'h0000, CMD_WAIT,     8'hFF, 1,  1'b1, ST_QUEUED,   8'h00, VALUE_NEG},
        '{1'b0, 16'h0000, CMD_WAIT,     8'hFF, 1,  1'b1, ST_QUEUED,   8'h00, VALUE_NEG},
        '{1'b0, 16'h0000, CMD_WAIT,     8'h00, 14, 1'b0, ST_QUEUED,   8'h00, VALUE_NEG},
        '{1'b0, 16'h0000, CMD_WAIT,     8'hA5, 1,  1'b1, ST_FULL,     8'h00, VALUE_NEG},
        '{1'b0, 16'h0000, CMD_TEST,     8'h00, 1,  1'b1, ST_BLOCK,    8'h00, VALUE_NEG},
        '{1'b0, 16'h0000, CMD_SPARE_LO, 8'h00, 1,  1'b1, ST_VALUE,    8'h00, VALUE_NEG},
        // timeout of a duplicate takes the oldest one only
        '{1'b0, 16'h0000, CMD_TIMEOUT,  8'hFF, 1,  1'b1, ST_REMOVED,  8'h00, VALUE_NEG},
        '{1'b0, 16'h0000, CMD_TIMEOUT,  8'h07, 1,  1'b0, ST_REMOVED,  8'h00, VALUE_NEG},
        '{1'b0, 16'h0000, CMD_TIMEOUT,  8'h99, 1,  1'b1, ST_NOTFOUND, 8'h00, VALUE_NEG},
        '{1'b0, 16'h0000, CMD_SIGNAL,   8'h00, 1,  1'b1, ST_WOKE,     8'hFF, VALUE_NEG},
        '{1'b0, 16'h0000, CMD_TIMEOUT,  8'h0D, 1,  1'b0, ST_REMOVED,  8'h00, VALUE_NEG},
        '{1'b0, 16'h0000, CMD_SIGNAL,   8'h00, 1,  1'b0, ST_WOKE,     8'h00, VALUE_NEG},
        // reload with waiters still queued, then saturate the count
        '{1'b1, 16'hFFFF, CMD_READ,     8'h00, 1,  1'b0, ST_VALUE,    8'h00, 17'd0},
        '{1'b0, 16'h0000, CMD_READ,     8'h00, 1,  1'b1, ST_VALUE,    8'h00, 17'd65535},
        '{1'b0, 16'h0000, CMD_SIGNAL,   8'h00, 1,  1'b1, ST_INCR,     8'h00, 17'd65535},
        '{1'b0, 16'h0000, CMD_WAIT,     8'h80, 1,  1'b1, ST_GRANTED,  8'h00, 17'd65534},
        '{1'b0, 16'h0000, CMD_SIGNAL,   8'h00, 1,  1'b0, ST_INCR,     8'h00, 17'd0},
        // back to empty, timeout of the only waiter
        '{1'b1, 16'h0000, CMD_READ,     8'h00, 1,  1'b0, ST_VALUE,    8'h00, 17'd0},
        '{1'b0, 16'h0000, CMD_WAIT,     8'h55, 1,  1'b1, ST_QUEUED,   8'h00, VALUE_NEG},
        '{1'b0, 16'h0000, CMD_TIMEOUT,  8'h55, 1,  1'b1, ST_REMOVED,  8'h00, 17'd0}
    };

    counting_semaphore_wait_queue_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // next state of the semaphore and the result item one command yields
    function automatic sem_result_t semaphore_step(input logic [2:0] op,
                                                   input logic [ID_W-1:0] who);
        sem_result_t res;
        int k;
        res.status = ST_VALUE;
        res.woken  = '0;
        case (op)
            CMD_WAIT:
            begin
                if (sem_count != 0)
                begin
                    sem_count--;
                    res.status = ST_GRANTED;
                end
                else if (waiter_ids.size() < MAX_WAITERS)
                begin
                    waiter_ids.push_back(who);
                    res.status = ST_QUEUED;
                end
                else
                begin
                    res.status = ST_FULL;
                end
            end
            CMD_TEST:
            begin
                if (sem_count != 0)
                begin
                    sem_count--;
                    res.status = ST_GRANTED;
                end
                else
                begin
                    res.status = ST_BLOCK;
                end
            end
            CMD_SIGNAL:
            begin
                if (waiter_ids.size() != 0)
                begin
                    res.woken  = waiter_ids.pop_front();
                    res.status = ST_WOKE;
                end
                else
                begin
                    // count sticks at its ceiling
                    if (sem_count != CNT_MAX)
                        sem_count++;
                    res.status = ST_INCR;
                end
            end
            CMD_TIMEOUT:
            begin
                res.status = ST_NOTFOUND;
                for (k = 0; k < waiter_ids.size(); k++)
                begin
                    if (waiter_ids[k] == who)
                    begin
                        waiter_ids.delete(k);
                        res.status = ST_REMOVED;
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.value = (waiter_ids.size() != 0) ? VALUE_NEG : {1'b0, sem_count};
        return res;
    endfunction

    // offer one command item, with a random gap first, and log what it owes
    task automatic send_item(input logic [2:0] op, input logic [ID_W-1:0] who,
                             input logic known, input sem_result_t typed);
        sem_result_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, who, op};
        do
            @(posedge clk);
        while (!s_tready);
        // accepted at this edge: advance the model now
        predicted = semaphore_step(op, who);
        pending_results.push_back(known ? typed : predicted);
        items_sent++;
    endtask

    // stop offering and wait until every owed result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // reload the count; only ever done with the block idle
    task automatic write_initial_count(input logic [CNT_W-1:0] val);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sem_count = val;
        waiter_ids.delete();
        count_settings++;
    endtask

    // random command, biased towards waits and signals so the queue fills
    // and drains; timeouts mostly name an id that really is queued
    task automatic random_item();
        logic [2:0]      op;
        logic [ID_W-1:0] who;
        int              roll;
        roll = $urandom_range(99);
        who  = ID_W'($urandom_range(255));
        if (roll < 36)
        begin
            op = CMD_WAIT;
            // a small id pool makes duplicates common
            if ($urandom_range(99) < 60)
                who = ID_W'($urandom_range(7));
        end
        else if (roll < 60)
        begin
            op = CMD_SIGNAL;
        end
        else if (roll < 76)
        begin
            op = CMD_TIMEOUT;
            if (waiter_ids.size() != 0 && $urandom_range(99) < 70)
                who = waiter_ids[$urandom_range(waiter_ids.size() - 1)];
        end
        else if (roll < 88)
        begin
            op = CMD_TEST;
        end
        else if (roll < 94)
        begin
            op = CMD_READ;
        end
        else
        begin
            op = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        end
        send_item(op, who, 1'b0, '0);
    endtask

    // receiver: random stalls, plus a long hold-off whenever one is asked for
    initial
    begin : result_sink
        int held;
        @(posedge clk);
        forever
        begin
            if (holds_served != holds_asked)
            begin
                holds_served++;
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
                @(posedge clk);
            end
        end
    end

    // result checker: each accepted result against the oldest one owed
    always @(posedge clk)
    begin : result_check
        sem_result_t want;
        sem_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = status_t'(m_tdata[3:0]);
            got.woken  = m_tdata[11:4];
            got.value  = m_tdata[28:12];
            results_seen++;
            if (m_tdata[3:0] < 9)
                status_seen[m_tdata[3:0]]++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: no result owed, actual status %0d woken %0d value %0h",
                         $time, got.status, got.woken, got.value);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, got.status);
                    mismatches++;
                end
                if (got.woken !== want.woken)
                begin
                    $display("%0t: woken mismatch, expected %0d, actual %0d",
                             $time, want.woken, got.woken);
                    mismatches++;
                end
                if (got.value !== want.value)
                begin
                    $display("%0t: value mismatch, expected %0h, actual %0h",
                             $time, want.value, got.value);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles with %0d results still owed",
                     $time, CYCLE_LIMIT, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                 r;
        int                 k;
        int                 p;
        int                 n;
        sem_result_t        typed;
        logic [CNT_W-1:0]   phase_cfg[NUM_PHASES];
        int                 phase_idle[NUM_PHASES];
        int                 phase_stall[NUM_PHASES];

        // counts kept small where the queue should see action; one phase at
        // the ceiling and one at a random value across the whole range
        phase_cfg   = '{16'h0000, 16'h0001, 16'hFFFF, 16'h0003, 16'h0002, 16'h0000, 16'h0000};
        phase_cfg[6] = CNT_W'($urandom_range(65535));
        phase_idle  = '{0, 49, 0, 32, 0, 49, 32};
        phase_stall = '{0, 0, 49, 32, 0, 49, 32};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling on either side
        for (r = 0; r < NUM_ROWS; r++)
        begin
            if (directed_steps[r].is_cfg)
            begin
                write_initial_count(directed_steps[r].cfg_val);
            end
            else
            begin
                typed.status = directed_steps[r].status;
                typed.woken  = directed_steps[r].woken;
                typed.value  = directed_steps[r].value;
                for (k = 0; k < directed_steps[r].reps; k++)
                    send_item(directed_steps[r].op, directed_steps[r].who + ID_W'(k),
                              directed_steps[r].known, typed);
            end
        end

        // random phases; each reload drains first, so the sender pauses
        // until nothing is owed at every phase boundary
        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_initial_count(phase_cfg[p]);
            src_idle_pct   = phase_idle[p];
            sink_stall_pct = phase_stall[p];
            // long receiver hold-off while the sender keeps offering
            if (p == 0 || p == 4)
                holds_asked++;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                random_item();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d command items, %0d results checked, %0d count settings",
                 items_sent, results_seen, count_settings);
        $write("status mix: grant %0d queue %0d block %0d wake %0d incr %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4]);
        $display(" read %0d rm %0d miss %0d full %0d",
                 status_seen[5], status_seen[6], status_seen[7], status_seen[8]);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/csq_pkg.sv
src/csq_queue.sv
src/counting_semaphore_wait_queue_unit.sv
tb/sv/counting_semaphore_wait_queue_unit_tb.sv
